// ===== hw/rtl/bda_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and breakpoint tables for the brightness to alpha converter.
// No dependencies; every other file imports this package.
package bda_pkg;

    localparam int BRIGHTNESS_BITS_DEFAULT = 12;
    localparam int ALPHA_BITS              = 8;
    localparam int LVL_BITS                = 10;  // breakpoint levels reach 1023
    localparam int SEG_BITS                = 8;   // widest segment spans 223 levels
    localparam int IDX_BITS                = 5;
    localparam int NORM_POINTS             = 20;
    localparam int DC_POINTS               = 23;
    localparam int HOLD_LIMIT              = 3;
    localparam int DIVIDEND_BITS           = 18;  // even: two quotient bits per cycle
    localparam int DIVISOR_BITS            = ALPHA_BITS + SEG_BITS;
    localparam int SUM_BITS                = 12;
    localparam int CFG_INDEX_BITS          = 2;
    localparam int CFG_DATA_BITS           = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_MODE     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_OVERRIDE = 2'd1;

    typedef struct packed {
        logic [LVL_BITS-1:0]   lvl;
        logic [ALPHA_BITS-1:0] val;
    } knot_t;

    typedef enum logic [2:0] {
        SRC_OVERRIDE,
        SRC_HOLD,
        SRC_FIRST,
        SRC_LAST,
        SRC_INTERP
    } res_src_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     idx_inc;
        logic     seg_load;
        logic     mul_load;
        logic     div_start;
        logic     div_sel;    // 0: linear term, 1: quadratic correction
        logic     bf_store;
        logic     res_load;
        res_src_t res_src;
        logic     out_load;
    } bda_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode_dc;
        logic override_nz;
        logic low_level;
        logic idx_end;
        logic idx_zero;
        logic lvl_ge;
        logic flat;
        logic div_busy;
    } bda_stat_t;

    function automatic knot_t knot(input logic dc, input logic [IDX_BITS-1:0] idx);
        knot_t k;
        k = '{lvl: '0, val: '0};
        if (dc) begin
            case (idx)
                5'd0:    k = '{10'd0,   8'hff};
                5'd1:    k = '{10'd1,   8'hfc};
                5'd2:    k = '{10'd2,   8'hfb};
                5'd3:    k = '{10'd3,   8'hfa};
                5'd4:    k = '{10'd4,   8'hf9};
                5'd5:    k = '{10'd5,   8'hf8};
                5'd6:    k = '{10'd6,   8'hf7};
                5'd7:    k = '{10'd8,   8'hf6};
                5'd8:    k = '{10'd10,  8'hf4};
                5'd9:    k = '{10'd15,  8'hf0};
                5'd10:   k = '{10'd20,  8'hea};
                5'd11:   k = '{10'd30,  8'he0};
                5'd12:   k = '{10'd45,  8'hd0};
                5'd13:   k = '{10'd70,  8'hbc};
                5'd14:   k = '{10'd100, 8'h98};
                5'd15:   k = '{10'd120, 8'h80};
                5'd16:   k = '{10'd140, 8'h70};
                5'd17:   k = '{10'd160, 8'h58};
                5'd18:   k = '{10'd180, 8'h48};
                5'd19:   k = '{10'd200, 8'h30};
                5'd20:   k = '{10'd220, 8'h20};
                5'd21:   k = '{10'd240, 8'h10};
                5'd22:   k = '{10'd260, 8'h00};
                default: k = '{10'd0,   8'h00};
            endcase
        end else begin
            case (idx)
                5'd0:    k = '{10'd0,    8'hff};
                5'd1:    k = '{10'd1,    8'hee};
                5'd2:    k = '{10'd2,    8'he8};
                5'd3:    k = '{10'd3,    8'he6};
                5'd4:    k = '{10'd4,    8'he5};
                5'd5:    k = '{10'd6,    8'he4};
                5'd6:    k = '{10'd10,   8'he0};
                5'd7:    k = '{10'd20,   8'hd5};
                5'd8:    k = '{10'd30,   8'hce};
                5'd9:    k = '{10'd45,   8'hc6};
                5'd10:   k = '{10'd70,   8'hb7};
                5'd11:   k = '{10'd100,  8'had};
                5'd12:   k = '{10'd150,  8'ha0};
                5'd13:   k = '{10'd227,  8'h8a};
                5'd14:   k = '{10'd300,  8'h80};
                5'd15:   k = '{10'd400,  8'h6e};
                5'd16:   k = '{10'd500,  8'h5b};
                5'd17:   k = '{10'd600,  8'h50};
                5'd18:   k = '{10'd800,  8'h38};
                5'd19:   k = '{10'd1023, 8'h18};
                default: k = '{10'd0,    8'h00};
            endcase
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/brightness_to_dim_alpha.sv =====
`timescale 1ns / 1ps
// Top level of the backlight brightness to dim-layer alpha converter.
// Depends on bda_pkg, bda_ctrl and bda_datapath (which holds bda_div).

// Converts a backlight brightness into an 8-bit dim-layer alpha by piecewise
// interpolation over a constant breakpoint table, with a quadratic correction
// term, clamped to 0..255. Register 0 (table_mode) selects the normal 20-point
// table (0) or the DC 23-point table (1); register 1 (alpha_override) forces the
// result in normal mode when nonzero. In normal mode a brightness of 3 or less
// returns the last alpha computed from the table. The block handles one item at
// a time. An override or hold result needs no table search; a result taken from
// the first or last breakpoint follows a table search of one step per
// breakpoint tried, plus one more when the brightness lies beyond the table.
// An interpolated result follows the search with two runs of the shared
// divider that yields two quotient bits per cycle (the second run is skipped
// on a flat segment). The next input transfer can be taken in the same cycle
// as the result is first offered. A finished result waits in the output
// register while the next input transfer is taken and worked on.
// Configuration writes are always accepted and must only be made while idle.
module brightness_to_dim_alpha #(
    parameter int BRIGHTNESS_BITS = bda_pkg::BRIGHTNESS_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((BRIGHTNESS_BITS+7)/8)*8-1:0] s_axis_tdata,  // [BRIGHTNESS_BITS-1:0] brightness
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bda_pkg::ALPHA_BITS-1:0]      m_axis_tdata,  // [7:0] alpha
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bda_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bda_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import bda_pkg::*;

    bda_cmd_t  cmd;
    bda_stat_t stat;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    bda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bda_datapath #(
        .BRIGHTNESS_BITS (BRIGHTNESS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .brightness (s_axis_tdata[BRIGHTNESS_BITS-1:0]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .alpha      (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/bda_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on bda_pkg for operand widths.
module bda_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [bda_pkg::DIVIDEND_BITS-1:0]  dividend,
    input  logic [bda_pkg::DIVISOR_BITS-1:0]   divisor,
    output logic                               busy,
    output logic [bda_pkg::DIVIDEND_BITS-1:0]  quotient
);
    import bda_pkg::*;

    localparam int DIV_CYCLES = DIVIDEND_BITS / 2;
    localparam int CNT_BITS   = $clog2(DIV_CYCLES + 1);

    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next, rem_mid;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next, quo_mid;
    logic [DIVISOR_BITS-1:0]  divisor_reg;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic [DIVISOR_BITS:0]    trial_a, trial_b;
    logic                     ge_a, ge_b;

    // two shift-subtract steps
    always_comb
    begin
        trial_a = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        ge_a    = (trial_a >= {1'b0, divisor_reg});
        rem_mid = ge_a ? DIVISOR_BITS'(trial_a - {1'b0, divisor_reg})
                       : trial_a[DIVISOR_BITS-1:0];
        quo_mid = {quo_reg[DIVIDEND_BITS-2:0], ge_a};

        trial_b = {rem_mid, quo_mid[DIVIDEND_BITS-1]};
        ge_b    = (trial_b >= {1'b0, divisor_reg});
        rem_next = ge_b ? DIVISOR_BITS'(trial_b - {1'b0, divisor_reg})
                        : trial_b[DIVISOR_BITS-1:0];
        quo_next = {quo_mid[DIVIDEND_BITS-2:0], ge_b};
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            cnt_next  = CNT_BITS'(DIV_CYCLES);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/bda_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, table search index, interpolation arithmetic,
// held alpha and output register. Depends on bda_pkg and bda_div.
module bda_datapath #(
    parameter int BRIGHTNESS_BITS = bda_pkg::BRIGHTNESS_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bda_pkg::bda_cmd_t                    cmd,
    output bda_pkg::bda_stat_t                   stat,
    input  logic [BRIGHTNESS_BITS-1:0]           brightness,
    input  logic                                 cfg_we,
    input  logic [bda_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bda_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic [bda_pkg::ALPHA_BITS-1:0]       alpha
);
    import bda_pkg::*;

    logic                       mode_reg;
    logic [ALPHA_BITS-1:0]      override_reg;
    logic [ALPHA_BITS-1:0]      held_reg;
    logic [ALPHA_BITS-1:0]      result_reg;
    logic [ALPHA_BITS-1:0]      alpha_reg;
    logic [BRIGHTNESS_BITS-1:0] x_reg;
    logic [IDX_BITS-1:0]        idx_reg;

    logic [ALPHA_BITS-1:0]      ya_reg;
    logic                       dy_neg_reg;
    logic [ALPHA_BITS-1:0]      dy_mag_reg;
    logic [SEG_BITS-1:0]        seg_reg, dx_reg, dxb_reg;
    logic [DIVIDEND_BITS-1:0]   prod_bf_reg, prod_sub_reg;
    logic [DIVISOR_BITS-1:0]    den_sub_reg;
    logic [ALPHA_BITS:0]        bf_reg;

    knot_t                      cur_knot, prev_knot;
    knot_t                      first_knot, last_knot;
    logic [IDX_BITS-1:0]        point_count;
    logic [LVL_BITS-1:0]        x_low;
    logic [ALPHA_BITS:0]        dy_diff;
    logic [LVL_BITS-1:0]        seg_full, dx_full, dxb_full;
    logic [ALPHA_BITS+SEG_BITS-1:0] mul_bf, mul_sub, mul_den;

    logic [DIVIDEND_BITS-1:0]   div_dividend, div_quotient;
    logic [DIVISOR_BITS-1:0]    div_divisor;
    logic                       div_busy;

    logic [ALPHA_BITS+1:0]      bf_round;
    logic [ALPHA_BITS:0]        lin_mag, sub_mag;
    logic [ALPHA_BITS+1:0]      corr_mag;
    logic signed [SUM_BITS-1:0] sum_val;
    logic [ALPHA_BITS-1:0]      interp_alpha;
    logic [ALPHA_BITS-1:0]      res_value;

    // table lookups
    assign point_count = mode_reg ? IDX_BITS'(DC_POINTS) : IDX_BITS'(NORM_POINTS);
    assign cur_knot    = knot(mode_reg, idx_reg);
    assign prev_knot   = knot(mode_reg, idx_reg - 1'b1);
    assign first_knot  = knot(mode_reg, '0);
    assign last_knot   = knot(mode_reg, point_count - 1'b1);
    assign x_low       = x_reg[LVL_BITS-1:0];

    // segment geometry; x lies inside the segment whenever it is loaded
    assign seg_full = cur_knot.lvl - prev_knot.lvl;
    assign dx_full  = x_low - prev_knot.lvl;
    assign dxb_full = cur_knot.lvl - x_low;
    assign dy_diff  = {1'b0, cur_knot.val} - {1'b0, prev_knot.val};

    assign mul_bf  = dy_mag_reg * dx_reg;
    assign mul_sub = dx_reg * dxb_reg;
    assign mul_den = dy_mag_reg * seg_reg;

    assign div_dividend = cmd.div_sel ? prod_sub_reg : prod_bf_reg;
    assign div_divisor  = cmd.div_sel ? den_sub_reg : DIVISOR_BITS'(seg_reg);

    bda_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // lin = ceil(|bf| / 2) carrying the sign of the slope; the correction takes it too
    always_comb
    begin
        bf_round  = {1'b0, bf_reg} + 1'b1;
        lin_mag   = bf_round[ALPHA_BITS+1:1];
        sub_mag   = (dy_mag_reg == '0) ? '0 : div_quotient[ALPHA_BITS:0];
        corr_mag  = {1'b0, lin_mag} + {1'b0, sub_mag};
        if (dy_neg_reg)
            sum_val = $signed(SUM_BITS'(ya_reg)) - $signed(SUM_BITS'(corr_mag));
        else
            sum_val = $signed(SUM_BITS'(ya_reg)) + $signed(SUM_BITS'(corr_mag));

        if (sum_val[SUM_BITS-1])
            interp_alpha = '0;
        else if (|sum_val[SUM_BITS-2:ALPHA_BITS])
            interp_alpha = '1;
        else
            interp_alpha = sum_val[ALPHA_BITS-1:0];
    end

    always_comb
    begin
        case (cmd.res_src)
            SRC_OVERRIDE: res_value = override_reg;
            SRC_HOLD:     res_value = held_reg;
            SRC_FIRST:    res_value = first_knot.val;
            SRC_LAST:     res_value = last_knot.val;
            SRC_INTERP:   res_value = interp_alpha;
            default:      res_value = held_reg;
        endcase
    end

    // configuration and state that reset clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg     <= 1'b0;
            override_reg <= '0;
            held_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TABLE_MODE:     mode_reg     <= cfg_data[0];
                    REG_ALPHA_OVERRIDE: override_reg <= cfg_data[ALPHA_BITS-1:0];
                    default:            ;
                endcase
            end
            if (cmd.res_load && !mode_reg
                && (cmd.res_src inside {SRC_FIRST, SRC_LAST, SRC_INTERP}))
                held_reg <= res_value;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            x_reg   <= brightness;
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + 1'b1;
        end

        if (cmd.seg_load) begin
            ya_reg     <= prev_knot.val;
            dy_neg_reg <= dy_diff[ALPHA_BITS];
            dy_mag_reg <= dy_diff[ALPHA_BITS] ? ALPHA_BITS'(-dy_diff) : dy_diff[ALPHA_BITS-1:0];
            seg_reg    <= seg_full[SEG_BITS-1:0];
            dx_reg     <= dx_full[SEG_BITS-1:0];
            dxb_reg    <= dxb_full[SEG_BITS-1:0];
        end

        if (cmd.mul_load) begin
            prod_bf_reg  <= DIVIDEND_BITS'({mul_bf, 1'b0});
            prod_sub_reg <= DIVIDEND_BITS'({mul_sub, 1'b0});
            den_sub_reg  <= mul_den;
        end

        if (cmd.bf_store)
            bf_reg <= div_quotient[ALPHA_BITS:0];

        if (cmd.res_load)
            result_reg <= res_value;

        if (cmd.out_load)
            alpha_reg <= result_reg;
    end

    assign stat.mode_dc     = mode_reg;
    assign stat.override_nz = (override_reg != '0);
    assign stat.low_level   = (x_reg <= BRIGHTNESS_BITS'(HOLD_LIMIT));
    assign stat.idx_end     = (idx_reg == point_count);
    assign stat.idx_zero    = (idx_reg == '0);
    assign stat.lvl_ge      = ({{(BRIGHTNESS_BITS-LVL_BITS){1'b0}}, cur_knot.lvl} >= x_reg);
    assign stat.flat        = (dy_mag_reg == '0);
    assign stat.div_busy    = div_busy;

    assign alpha = alpha_reg;

endmodule

// ===== hw/rtl/bda_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences classify, table search, interpolation and result transfer.
// Depends on bda_pkg for the command and status structs.
module bda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bda_pkg::bda_stat_t  stat,
    output bda_pkg::bda_cmd_t   cmd
);
    import bda_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_SEARCH,
        ST_LOAD,
        ST_MUL,
        ST_BF_START,
        ST_BF_WAIT,
        ST_SUB_START,
        ST_SUB_WAIT,
        ST_SUM,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.res_src    = SRC_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                if (!stat.mode_dc && stat.override_nz) begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = SRC_OVERRIDE;
                    state_next   = ST_FINISH;
                end else if (!stat.mode_dc && stat.low_level) begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = SRC_HOLD;
                    state_next   = ST_FINISH;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.idx_end) begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = SRC_LAST;
                    state_next   = ST_FINISH;
                end else if (stat.lvl_ge) begin
                    if (stat.idx_zero) begin
                        cmd.res_load = 1'b1;
                        cmd.res_src  = SRC_FIRST;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_LOAD:
            begin
                cmd.seg_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_BF_START;
            end
            ST_BF_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_BF_WAIT;
            end
            ST_BF_WAIT:
            begin
                if (!stat.div_busy) begin
                    cmd.bf_store = 1'b1;
                    state_next   = stat.flat ? ST_SUM : ST_SUB_START;
                end
            end
            ST_SUB_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = ST_SUB_WAIT;
            end
            ST_SUB_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = SRC_INTERP;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/bda_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the brightness to alpha converter, bound to the top level.
// Depends on bda_pkg for the alpha width.
module bda_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [bda_pkg::ALPHA_BITS-1:0] m_axis_tdata,
    input logic                           cfg_ready
);
    import bda_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // one item at a time: no second transfer straight after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // the classify and finish states lie between an input transfer and its result
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // configuration is never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind brightness_to_dim_alpha bda_checker u_bda_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_ready     (cfg_ready)
);

// ===== dv/brightness_to_dim_alpha_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for brightness_to_dim_alpha: streams brightness levels in,
// predicts each dim-layer alpha and checks it against the result stream.
// Depends on bda_pkg and the brightness_to_dim_alpha RTL.
module brightness_to_dim_alpha_tb;

    import bda_pkg::*;

    localparam int LEVEL_BITS = BRIGHTNESS_BITS_DEFAULT;
    localparam int LEVEL_DATA_BITS = ((LEVEL_BITS + 7) / 8) * 8;

    // Register indexes the block does not decode; writes to them must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    // How the result side applies back-pressure
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_RUNS
    } rx_mode_t;

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [LEVEL_DATA_BITS-1:0]  s_axis_tdata;   // [11:0] brightness
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [ALPHA_BITS-1:0]       m_axis_tdata;   // [7:0] alpha
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index;
    logic [CFG_DATA_BITS-1:0]    cfg_data;

    // Breakpoint tables: brightness level and alpha of each knot
    int norm_lvl [NORM_POINTS] = '{0, 1, 2, 3, 4, 6, 10, 20, 30, 45,
                                   70, 100, 150, 227, 300, 400, 500, 600, 800, 1023};
    int norm_val [NORM_POINTS] = '{'hff, 'hee, 'he8, 'he6, 'he5, 'he4, 'he0, 'hd5, 'hce,
                                   'hc6, 'hb7, 'had, 'ha0, 'h8a, 'h80, 'h6e, 'h5b, 'h50,
                                   'h38, 'h18};
    int dc_lvl [DC_POINTS] = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 45, 70, 100,
                               120, 140, 160, 180, 200, 220, 240, 260};
    int dc_val [DC_POINTS] = '{'hff, 'hfc, 'hfb, 'hfa, 'hf9, 'hf8, 'hf7, 'hf6, 'hf4,
                               'hf0, 'hea, 'he0, 'hd0, 'hbc, 'h98, 'h80, 'h70, 'h58,
                               'h48, 'h30, 'h20, 'h10, 'h00};

    // Shadow of the block's registers and held alpha
    logic                  dc_mode_shadow;
    logic [ALPHA_BITS-1:0] override_shadow;
    logic [ALPHA_BITS-1:0] held_alpha;

    // Alphas still owed by the block, oldest first
    logic [ALPHA_BITS-1:0] alpha_queue [$];
    int                    fail_count;

    // Sender and receiver pacing
    int       gap_max;
    int       burst_left;
    rx_mode_t rx_mode;
    int       hold_off_req;

    brightness_to_dim_alpha #(
        .BRIGHTNESS_BITS (LEVEL_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Generous limit: the slowest legal run stays well below a tenth of this
    initial
    begin
        #20_000_000;
        $display("brightness_to_dim_alpha test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Level (want_val = 0) or alpha (want_val = 1) of knot k of either table
    function automatic int knot_at(input bit dc, input int k, input bit want_val);
        if (dc)
            return want_val ? dc_val[k] : dc_lvl[k];
        return want_val ? norm_val[k] : norm_lvl[k];
    endfunction

    // Piecewise interpolation with the quadratic correction; all divisions
    // truncate towards zero, as signed int division does
    function automatic logic [ALPHA_BITS-1:0] table_alpha(input bit dc, input int x);
        int n, k, xa, xb, ya, yb, bf, lin, corr, acc;
        n = dc ? DC_POINTS : NORM_POINTS;
        k = 0;
        while (k < n && knot_at(dc, k, 1'b0) < x)
            k++;
        if (k == 0)
            return ALPHA_BITS'(knot_at(dc, 0, 1'b1));
        if (k == n)
            return ALPHA_BITS'(knot_at(dc, n - 1, 1'b1));
        xa = knot_at(dc, k - 1, 1'b0);
        xb = knot_at(dc, k, 1'b0);
        ya = knot_at(dc, k - 1, 1'b1);
        yb = knot_at(dc, k, 1'b1);
        bf = 2 * (yb - ya) * (x - xa) / (xb - xa);
        lin = bf / 2 + bf % 2;
        corr = 0;
        if (yb != ya)
            corr = 2 * (x - xa) * (x - xb) / (yb - ya) / (xa - xb);
        acc = ya + lin + corr;
        if (acc < 0)
            acc = 0;
        else if (acc > 255)
            acc = 255;
        return acc[ALPHA_BITS-1:0];
    endfunction

    // Alpha for one brightness transfer; updates the held alpha as the block does
    function automatic logic [ALPHA_BITS-1:0] predict_alpha(input logic [LEVEL_BITS-1:0] level);
        logic [ALPHA_BITS-1:0] a;
        if (dc_mode_shadow)
            a = table_alpha(1'b1, level);
        else if (override_shadow != '0)
            a = override_shadow;
        else if (level <= HOLD_LIMIT)
            a = held_alpha;
        else
        begin
            a = table_alpha(1'b0, level);
            held_alpha = a;
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Result side: back-pressure and checking
    // ------------------------------------------------------------------

    // Drive tready at the falling edge. A long hold-off request takes
    // priority and is counted down here, one cycle at a time.
    initial
    begin : result_pacing
        int             hold_left;
        int             run_left;
        logic           run_ready;
        logic [7:0]     pattern;
        hold_left = 0;
        run_left = 0;
        run_ready = 1'b1;
        pattern = 8'b1101_0110;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req != 0)
            begin
                hold_left = hold_off_req;
                hold_off_req = 0;
            end
            pattern = {pattern[6:0], pattern[7]};
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 99) < 65);
                    RX_PATTERN: m_axis_tready <= pattern[0];
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_ready = ~run_ready;
                            run_left = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 60);
                        end
                        run_left--;
                        m_axis_tready <= run_ready;
                    end
                endcase
            end
        end
    end

    // Compare every result transfer with the oldest expected alpha
    always @(posedge clk)
    begin : alpha_check
        logic [ALPHA_BITS-1:0] want_alpha;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (alpha_queue.size() == 0)
            begin
                $error("alpha: expected none, actual %0d", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want_alpha = alpha_queue.pop_front();
                if (m_axis_tdata !== want_alpha)
                begin
                    $error("alpha: expected %0d, actual %0d", want_alpha, m_axis_tdata);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one brightness and hold it until the transfer. Entered and left
    // at a falling edge; tvalid stays high afterwards so that the next call
    // can follow back to back; it is dropped only for a gap between bursts or by drain_results.
    task automatic send_level(input logic [LEVEL_BITS-1:0] level);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(LEVEL_DATA_BITS - LEVEL_BITS){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_axis_tready);
        alpha_queue.push_back(predict_alpha(level));
        @(negedge clk);
    endtask

    // Drop tvalid, wait for every owed alpha, then idle before returning
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (alpha_queue.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_TABLE_MODE)
            dc_mode_shadow = data[0];
        else if (index == REG_ALPHA_OVERRIDE)
            override_shadow = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random brightness, weighted towards the breakpoints and the table ranges
    function automatic logic [LEVEL_BITS-1:0] pick_level();
        int r, k, lvl;
        r = $urandom_range(0, 99);
        if (r < 12)
            return LEVEL_BITS'($urandom);
        if (r < 22)
            return LEVEL_BITS'($urandom_range(0, 8));
        if (r < 45)
            return LEVEL_BITS'($urandom_range(0, 270));
        if (r < 75)
            return LEVEL_BITS'($urandom_range(0, 1030));
        // hit a knot or one of its neighbours
        k = $urandom_range(0, (dc_mode_shadow ? DC_POINTS : NORM_POINTS) - 1);
        lvl = knot_at(dc_mode_shadow, k, 1'b0) + $urandom_range(0, 2) - 1;
        if (lvl < 0)
            lvl = 0;
        return lvl[LEVEL_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Held alpha comes out of reset as zero
    task automatic test_hold_after_reset();
        send_level(0);
        send_level(3);
        drain_results();
    endtask

    // Normal table: first interpolated segment, a knot and its neighbour,
    // the last knot, beyond the table, then the hold of the last computed alpha
    task automatic test_normal_table();
        send_level(4);
        send_level(5);
        send_level(227);
        send_level(228);
        send_level(1023);
        send_level(1024);
        send_level(12'hfff);
        send_level(12'h800);
        send_level(2);
        drain_results();
    endtask

    // Override wins in normal mode and leaves the held alpha alone
    task automatic test_override();
        write_reg(REG_ALPHA_OVERRIDE, 8'h80);
        send_level(500);
        send_level(1);
        drain_results();
        write_reg(REG_ALPHA_OVERRIDE, 8'hff);
        send_level(12'hfff);
        drain_results();
        write_reg(REG_ALPHA_OVERRIDE, 8'h00);
        send_level(3);
        drain_results();
    endtask

    // DC table ignores override and hold; unused register indexes do nothing;
    // only bit 0 of the table mode write counts
    task automatic test_dc_table();
        write_reg(REG_TABLE_MODE, 8'h01);
        send_level(0);
        send_level(130);
        send_level(260);
        send_level(261);
        drain_results();
        write_reg(REG_ALPHA_OVERRIDE, 8'h5a);
        send_level(2);
        drain_results();
        write_reg(REG_SPARE_2, 8'hff);
        write_reg(REG_SPARE_3, 8'hff);
        send_level(7);
        drain_results();
        write_reg(REG_TABLE_MODE, 8'hfe);
        write_reg(REG_ALPHA_OVERRIDE, 8'h00);
        send_level(1);
        drain_results();
    endtask

    // Stall the result side for a long stretch while levels keep coming, so
    // the block fills and stalls its input; then pause until all is back
    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        gap_max = 0;
        burst_left = 0;
        hold_off_req = 400;
        repeat (10) send_level(pick_level());
        drain_results();
    endtask

    // Random levels across register settings and pacing styles
    task automatic test_random_levels();
        int p, count;
        logic [CFG_DATA_BITS-1:0] ovr;
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: begin ovr = 8'h00; rx_mode = RX_ALWAYS;  gap_max = 0;  count = 300; end
                1: begin ovr = 8'h00; rx_mode = RX_RANDOM;  gap_max = 3;  count = 250; end
                2: begin ovr = 8'h00; rx_mode = RX_PATTERN; gap_max = 10; count = 250; end
                3: begin ovr = CFG_DATA_BITS'($urandom_range(1, 254)); rx_mode = RX_RUNS;
                         gap_max = 2; count = 60; end
                4: begin ovr = 8'hff; rx_mode = RX_RANDOM;  gap_max = 60; count = 150; end
                5: begin ovr = 8'h00; rx_mode = RX_RUNS;    gap_max = 5;  count = 250; end
                6: begin ovr = 8'h00; rx_mode = RX_ALWAYS;  gap_max = 1;  count = 250; end
                default: begin ovr = 8'hff; rx_mode = RX_PATTERN; gap_max = 4; count = 60; end
            endcase
            // DC mode on the odd phases; random upper bits must be masked off
            write_reg(REG_TABLE_MODE, {7'($urandom), p[0]});
            write_reg(REG_ALPHA_OVERRIDE, ovr);
            write_reg(p[1] ? REG_SPARE_3 : REG_SPARE_2, 8'($urandom));
            burst_left = 0;
            repeat (count) send_level(pick_level());
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Initialise every input and the shadow state before reset
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        dc_mode_shadow = 1'b0;
        override_shadow = '0;
        held_alpha = '0;
        fail_count = 0;
        gap_max = 2;
        burst_left = 0;
        rx_mode = RX_RANDOM;
        hold_off_req = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_hold_after_reset();
        test_normal_table();
        test_override();
        test_dc_table();
        test_backpressure();
        test_random_levels();

        // Catch any stray result after the last expected one
        drain_results();
        repeat (60) @(posedge clk);

        if (fail_count == 0)
            $display("brightness_to_dim_alpha test passed");
        else
            $display("brightness_to_dim_alpha test failed");
        $finish;
    end

endmodule
